FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/cdu_pkg.sv
// ---------------------------------------------------------------------------
// cdu_pkg
// Types, widths and month tables of the calendar date unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cdu_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int QUO_W   = 8;   // year / 100 for 14-bit years
    localparam int WSUM_W  = 15;  // weekday sum before mod 7
    localparam int DOY_W   = 9;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 48;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // stage 1: raw date plus quotients by 100
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [YEAR_W-1:0]  yy;       // year, less one for Jan/Feb
        logic [QUO_W-1:0]   y_q100;
        logic [QUO_W-1:0]   yy_q100;
    } s1_t;

    // stage 2: leap, month length, validity, weekday sum
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               leap;
        logic [DAY_W-1:0]   dim;
        logic               valid;
        logic [WSUM_W-1:0]  wsum;
    } s2_t;

    // result item; last member sits in the lowest bits
    typedef struct packed {
        logic [DOY_W-1:0]   days_left_in_year;
        logic [DAY_W-1:0]   days_left_in_month;
        logic [2:0]         days_to_saturday;
        logic               is_business_day;
        logic               is_weekend;
        logic               is_sunday;
        logic [2:0]         weekday;
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_day;
        logic               date_valid;
    } out_t;

    // non-leap month length, 0 for codes that are no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
            4'd2:                                        r = 5'd28;
            default:                                     r = 5'd0;
        endcase
        return r;
    endfunction

    // days before the first of the month, non-leap
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // (31 * shifted month) / 12, reduced mod 7
    function automatic logic [2:0] month_key(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cdu_div100.sv
// ---------------------------------------------------------------------------
// cdu_div100
// Divide a 14-bit value by 100: multiply by 5243 / 2^19, exact below 16384.
// ---------------------------------------------------------------------------
`default_nettype none

module cdu_div100
    import cdu_pkg::*;
(
    input  wire logic [YEAR_W-1:0] num,
    output logic      [QUO_W-1:0]  quo
);

    localparam logic [12:0] RECIP_100 = 13'd5243;

    logic [YEAR_W+12:0] prod;

    assign prod = {13'd0, num} * {{YEAR_W{1'b0}}, RECIP_100};
    assign quo  = prod[YEAR_W+12 -: QUO_W];

endmodule

`default_nettype wire

FILE: rtl/calendar_date_unit_top.sv
// ---------------------------------------------------------------------------
// calendar_date_unit_top
// Stateless Gregorian date unit: next date, weekday and day counts.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one date per item (day, month, year in s_tdata).
//   Result channel m_*: one result item per input item, same order.
//   Invalid dates (bad month, day, or year 0 / above MAX_YEAR) give
//   date_valid = 0 and every other result field zero.
// Pipeline: three register stages; an accepted item moves from stage 1
//   through stage 2 into the output register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready is high; three register stages
//   (divide by 100 -> leap/limits/weekday sum -> mod 7 and counts),
//   each stage holding one item with its own valid bit.
// Stall: when m_tready is low the output stage holds its item; upstream
//   stages keep moving until they fill, then s_tready drops. Nothing is
//   dropped or repeated.
// Reset: aresetn low (synchronous) clears all stage valid bits; the
//   pipeline comes up empty and ready.
// ---------------------------------------------------------------------------
`default_nettype none

module calendar_date_unit_top
    import cdu_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // tdata: day[4:0], month[8:5], year[22:9], zero pad [23]
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    // tdata: date_valid[0], next_day[5:1], next_month[9:6], next_year[23:10],
    //        weekday[26:24], is_sunday[27], is_weekend[28],
    //        is_business_day[29], days_to_saturday[32:30],
    //        days_left_in_month[37:33], days_left_in_year[46:38], pad [47]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam logic [YEAR_W:0] MaxYearW = (YEAR_W + 1)'(MAX_YEAR);

    // ---- handshake / stage enables ----
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic en1, en2, en3;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    assign v1_next = en1 ? s_tvalid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ---- stage 1: unpack, shifted year, quotients by 100 ----
    s1_t s1_reg, s1_next;
    logic [DAY_W-1:0]   in_day;
    logic [MONTH_W-1:0] in_month;
    logic [YEAR_W-1:0]  in_year;
    logic [YEAR_W-1:0]  in_yy;
    logic [QUO_W-1:0]   y_q100;
    logic [QUO_W-1:0]   yy_q100;

    assign in_day   = s_tdata[DAY_W-1:0];
    assign in_month = s_tdata[DAY_W +: MONTH_W];
    assign in_year  = s_tdata[DAY_W+MONTH_W +: YEAR_W];
    // Jan and Feb count as months 11 and 12 of the year before
    assign in_yy    = in_year - {{(YEAR_W-1){1'b0}}, (in_month <= MONTH_FEB)};

    cdu_div100 u_div_y (
        .num (in_year),
        .quo (y_q100)
    );

    cdu_div100 u_div_yy (
        .num (in_yy),
        .quo (yy_q100)
    );

    always_comb begin
        s1_next.day     = in_day;
        s1_next.month   = in_month;
        s1_next.year    = in_year;
        s1_next.yy      = in_yy;
        s1_next.y_q100  = y_q100;
        s1_next.yy_q100 = yy_q100;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg <= s1_next;
        end
    end

    // ---- stage 2: leap year, month length, validity, weekday sum ----
    s2_t s2_reg, s2_next;
    logic [YEAR_W:0]   hundreds;
    logic              div_100;
    logic              leap;
    logic [DAY_W-1:0]  dim;
    logic              month_ok;

    always_comb begin
        hundreds = {1'b0, s1_reg.y_q100, 6'd0} + {2'b0, s1_reg.y_q100, 5'd0}
                 + {5'b0, s1_reg.y_q100, 2'd0};
        div_100  = (hundreds == {1'b0, s1_reg.year});
        // by 4 and not by 100, or by 400
        leap     = (s1_reg.year[1:0] == 2'd0) && (!div_100 || s1_reg.y_q100[1:0] == 2'd0);
        if (s1_reg.month == MONTH_FEB) begin
            dim = leap ? 5'd29 : 5'd28;
        end else begin
            dim = month_len(s1_reg.month);
        end
        month_ok = s1_reg.month inside {[MONTH_JAN:MONTH_DEC]};

        s2_next.day   = s1_reg.day;
        s2_next.month = s1_reg.month;
        s2_next.year  = s1_reg.year;
        s2_next.leap  = leap;
        s2_next.dim   = dim;
        s2_next.valid = month_ok && (s1_reg.day != '0) && (s1_reg.day <= dim)
                      && (s1_reg.year != '0) && ({1'b0, s1_reg.year} <= MaxYearW);
        // d + yy + yy/4 - yy/100 + yy/400 + month key
        s2_next.wsum  = {{(WSUM_W-DAY_W){1'b0}}, s1_reg.day}
                      + {1'b0, s1_reg.yy}
                      + {3'b0, s1_reg.yy[YEAR_W-1:2]}
                      - {{(WSUM_W-QUO_W){1'b0}}, s1_reg.yy_q100}
                      + {{(WSUM_W-QUO_W+2){1'b0}}, s1_reg.yy_q100[QUO_W-1:2]}
                      + {{(WSUM_W-3){1'b0}}, month_key(s1_reg.month)};
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_reg <= s2_next;
        end
    end

    // ---- stage 3: mod 7, next date, counts, output register ----
    out_t out_reg, out_next;
    logic [5:0]        fold1;
    logic [3:0]        fold2;
    logic [2:0]        wd;
    logic              last_day;
    logic [DOY_W-1:0]  doy;
    logic [DOY_W-1:0]  diy;

    always_comb begin
        // 8 = 1 mod 7: sum the octal digits, twice, then one correction
        fold1 = {3'b0, s2_reg.wsum[2:0]} + {3'b0, s2_reg.wsum[5:3]}
              + {3'b0, s2_reg.wsum[8:6]} + {3'b0, s2_reg.wsum[11:9]}
              + {3'b0, s2_reg.wsum[14:12]};
        fold2 = {1'b0, fold1[5:3]} + {1'b0, fold1[2:0]};
        wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

        last_day = (s2_reg.day == s2_reg.dim);
        doy      = days_before(s2_reg.month) + {4'b0, s2_reg.day}
                 + {8'b0, (s2_reg.leap && s2_reg.month > MONTH_FEB)};
        diy      = s2_reg.leap ? 9'd366 : 9'd365;

        out_next = '0;
        if (s2_reg.valid) begin
            out_next.date_valid = 1'b1;
            if (last_day) begin
                out_next.next_day = 5'd1;
                if (s2_reg.month == MONTH_DEC) begin
                    out_next.next_month = MONTH_JAN;
                    out_next.next_year  = s2_reg.year + 14'd1;   // wraps past 14 bits
                end else begin
                    out_next.next_month = s2_reg.month + 4'd1;
                    out_next.next_year  = s2_reg.year;
                end
            end else begin
                out_next.next_day   = s2_reg.day + 5'd1;
                out_next.next_month = s2_reg.month;
                out_next.next_year  = s2_reg.year;
            end
            out_next.weekday            = wd;
            out_next.is_sunday          = (wd == 3'd0);
            out_next.is_weekend         = (wd == 3'd0) || (wd == 3'd6);
            out_next.is_business_day    = !((wd == 3'd0) || (wd == 3'd6));
            out_next.days_to_saturday   = 3'd6 - wd;
            out_next.days_left_in_month = s2_reg.dim - s2_reg.day + 5'd1;
            out_next.days_left_in_year  = diy - doy + 9'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

`default_nettype wire

FILE: rtl/cdu_checker.sv
// ---------------------------------------------------------------------------
// cdu_checker
// Port-level checks of the calendar date unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdu_checker
    import cdu_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tready,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata
);

    // a stalled result holds
    `ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // invalid date: every other field is zero
    `ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tdata[0], m_tdata[OUT_W-1:1] == '0)

    // weekday in range and business day is the inverse of weekend
    `ASSERT_NOW(a_flags, m_tvalid && m_tdata[0],
                m_tdata[26:24] != 3'd7 && m_tdata[29] != m_tdata[28])

    // days to Saturday plus weekday is six
    `ASSERT_NOW(a_sat_count, m_tvalid && m_tdata[0], 3'(m_tdata[32:30] + m_tdata[26:24]) == 3'd6)

    // a ready receiver always opens the input side
    `ASSERT_NOW(a_ready_path, m_tready, s_tready)

endmodule

bind calendar_date_unit_top cdu_checker u_cdu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for calendar_date_unit_top: dates go in on s_*, and
// every result on m_* is checked field by field against a local date model.
// ---------------------------------------------------------------------------

module tb;
    import cdu_pkg::*;

    localparam int LAST_YEAR  = 9999;
    localparam int TIMEOUT_NS = 20_000_000;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // predicted result items, oldest first
    out_t date_answers[$];

    int n_dates      = 0;
    int n_valid      = 0;
    int n_invalid    = 0;
    int n_month_roll = 0;
    int n_year_roll  = 0;
    int n_results    = 0;
    int n_errors     = 0;

    // sender burst shaping
    bit gaps_on    = 1'b0;
    int burst_left = 0;

    // receiver stall pattern; the top two bits of stall_tick pick the mode
    logic [9:0] stall_tick = '0;

    calendar_date_unit_top #(
        .MAX_YEAR (LAST_YEAR)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // date model
    // -----------------------------------------------------------------------
    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // length of month m in year y, zero for a code that is no month
    function automatic int days_in_month(input int m, input int y);
        int len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic out_t predict_date(input logic [DAY_W-1:0] day_in,
                                          input logic [MONTH_W-1:0] month_in,
                                          input logic [YEAR_W-1:0] year_in);
        out_t r;
        int d, m, y, dim, shift, yy, mm, wd, doy, diy;
        r   = '0;
        d   = int'(day_in);
        m   = int'(month_in);
        y   = int'(year_in);
        dim = days_in_month(m, y);
        if (dim == 0 || d < 1 || d > dim || y < 1 || y > LAST_YEAR)
            return r;

        // Zeller-style count with March as the first month of the year
        shift = (m <= int'(MONTH_FEB)) ? 1 : 0;
        yy    = y - shift;
        mm    = m + 12 * shift - 2;
        wd    = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;

        doy = d;
        for (int k = 1; k < m; k++)
            doy += days_in_month(k, y);
        diy = is_leap(y) ? 366 : 365;

        r.date_valid = 1'b1;
        if (d == dim) begin
            r.next_day = 5'd1;
            if (m == int'(MONTH_DEC)) begin
                r.next_month = MONTH_JAN;
                r.next_year  = YEAR_W'(y + 1);
            end else begin
                r.next_month = MONTH_W'(m + 1);
                r.next_year  = YEAR_W'(y);
            end
        end else begin
            r.next_day   = DAY_W'(d + 1);
            r.next_month = MONTH_W'(m);
            r.next_year  = YEAR_W'(y);
        end
        r.weekday            = 3'(wd);
        r.is_sunday          = (wd == 0);
        r.is_weekend         = (wd == 0) || (wd == 6);
        r.is_business_day    = !((wd == 0) || (wd == 6));
        r.days_to_saturday   = 3'(6 - wd);
        r.days_left_in_month = DAY_W'(dim - d + 1);
        r.days_left_in_year  = DOY_W'(diy - doy + 1);
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // sender
    // -----------------------------------------------------------------------
    // Called right after a rising edge. Holds the item until s_tready is
    // seen high at a falling edge, so the edge that follows takes it.
    task automatic send_date(input logic [DAY_W-1:0] d,
                             input logic [MONTH_W-1:0] m,
                             input logic [YEAR_W-1:0] y);
        bit   taken;
        int   gap;
        out_t want;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, y, m, d};
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
        want = predict_date(d, m, y);
        date_answers.push_back(want);
        n_dates++;
        if (want.date_valid) begin
            n_valid++;
            if (want.next_day == 5'd1)
                n_month_roll++;
            if (want.next_month == MONTH_JAN && want.next_day == 5'd1)
                n_year_roll++;
        end else begin
            n_invalid++;
        end

        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 7);
                burst_left = $urandom_range(1, 24);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    // drop valid and wait for every predicted result to come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (date_answers.size() != 0)
            @(posedge aclk);
    endtask

    // a real date; years lean toward century and leap boundaries
    task automatic send_random_valid();
        logic [YEAR_W-1:0] y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0] d;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            y = YEAR_W'($urandom_range(1, LAST_YEAR));
        end else begin
            case ($urandom_range(0, 12))
                0:       y = 14'd1;
                1:       y = 14'd4;
                2:       y = 14'd99;
                3:       y = 14'd100;
                4:       y = 14'd400;
                5:       y = 14'd1600;
                6:       y = 14'd1900;
                7:       y = 14'd2000;
                8:       y = 14'd2100;
                9:       y = 14'd2024;
                10:      y = 14'd9996;
                11:      y = 14'd9900;
                default: y = LAST_YEAR[YEAR_W-1:0];
            endcase
        end
        m = MONTH_W'($urandom_range(1, 12));
        d = DAY_W'($urandom_range(1, days_in_month(int'(m), int'(y))));
        send_date(d, m, y);
    endtask

    // any bit pattern the fields can carry
    task automatic send_random_raw();
        send_date(DAY_W'($urandom_range(0, 31)), MONTH_W'($urandom_range(0, 15)),
                  YEAR_W'($urandom_range(0, 16383)));
    endtask

    // -----------------------------------------------------------------------
    // receiver: cycles through always-ready, random, periodic and long stalls
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 10'd1;
        case (stall_tick[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= (stall_tick[2:0] < 3'd3);
            default: m_tready <= (stall_tick[3:0] == 4'd0) || ($urandom_range(0, 9) == 0);
        endcase
    end

    // -----------------------------------------------------------------------
    // result checker; outputs are stable at the falling edge, and an item
    // seen with valid and ready high there is taken at the next rising edge
    // -----------------------------------------------------------------------
    task automatic report_field(input string name, input int want, input int got);
        n_errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(negedge aclk) begin
        out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = out_t'(m_tdata[$bits(out_t)-1:0]);
            if (date_answers.size() == 0) begin
                n_errors++;
                $display("%0t ns: result item with none expected, tdata %h", $time, m_tdata);
            end else begin
                want = date_answers.pop_front();
                n_results++;
                if (got.date_valid !== want.date_valid)
                    report_field("date_valid", int'(want.date_valid),
                                 int'(got.date_valid));
                if (got.next_day !== want.next_day)
                    report_field("next_day", int'(want.next_day), int'(got.next_day));
                if (got.next_month !== want.next_month)
                    report_field("next_month", int'(want.next_month),
                                 int'(got.next_month));
                if (got.next_year !== want.next_year)
                    report_field("next_year", int'(want.next_year), int'(got.next_year));
                if (got.weekday !== want.weekday)
                    report_field("weekday", int'(want.weekday), int'(got.weekday));
                if (got.is_sunday !== want.is_sunday)
                    report_field("is_sunday", int'(want.is_sunday), int'(got.is_sunday));
                if (got.is_weekend !== want.is_weekend)
                    report_field("is_weekend", int'(want.is_weekend),
                                 int'(got.is_weekend));
                if (got.is_business_day !== want.is_business_day)
                    report_field("is_business_day", int'(want.is_business_day),
                                 int'(got.is_business_day));
                if (got.days_to_saturday !== want.days_to_saturday)
                    report_field("days_to_saturday", int'(want.days_to_saturday),
                                 int'(got.days_to_saturday));
                if (got.days_left_in_month !== want.days_left_in_month)
                    report_field("days_left_in_month", int'(want.days_left_in_month),
                                 int'(got.days_left_in_month));
                if (got.days_left_in_year !== want.days_left_in_year)
                    report_field("days_left_in_year", int'(want.days_left_in_year),
                                 int'(got.days_left_in_year));
            end
        end
    end

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    // field extremes, leap rules, rollovers and every kind of invalid date
    task automatic test_directed();
        gaps_on = 1'b0;
        send_date(5'd1,  4'd1,  14'd1);       // first date of the range
        send_date(5'd31, 4'd12, 14'd9999);    // last date, year rolls past range
        send_date(5'd1,  4'd1,  14'd9999);
        send_date(5'd31, 4'd12, 14'd1);
        send_date(5'd28, 4'd2,  14'd2000);
        send_date(5'd29, 4'd2,  14'd2000);    // leap by the 400 rule
        send_date(5'd28, 4'd2,  14'd1900);
        send_date(5'd29, 4'd2,  14'd1900);    // century, not leap
        send_date(5'd29, 4'd2,  14'd2024);
        send_date(5'd29, 4'd2,  14'd2023);    // not leap
        send_date(5'd29, 4'd2,  14'd400);
        send_date(5'd29, 4'd2,  14'd9996);
        send_date(5'd31, 4'd12, 14'd2023);
        send_date(5'd31, 4'd1,  14'd2024);
        send_date(5'd30, 4'd4,  14'd2024);
        send_date(5'd31, 4'd4,  14'd2024);    // past end of a 30-day month
        send_date(5'd0,  4'd5,  14'd2024);    // day zero
        send_date(5'd15, 4'd0,  14'd2024);    // month zero
        send_date(5'd15, 4'd13, 14'd2024);    // month past December
        send_date(5'd31, 4'd15, 14'd16383);   // all ones
        send_date(5'd1,  4'd1,  14'd0);       // year zero
        send_date(5'd1,  4'd1,  14'd10000);   // year past the top
        send_date(5'd7,  4'd6,  14'd2025);    // Saturday
        send_date(5'd8,  4'd6,  14'd2025);    // Sunday
        wait_drained();
    endtask

    task automatic test_valid_dates();
        gaps_on = 1'b1;
        repeat (550) send_random_valid();
        wait_drained();
    endtask

    // last day of a month, a good share of them in December
    task automatic test_month_and_year_ends();
        logic [YEAR_W-1:0] y;
        logic [MONTH_W-1:0] m;
        gaps_on = 1'b1;
        repeat (250) begin
            y = YEAR_W'($urandom_range(1, LAST_YEAR));
            m = ($urandom_range(0, 2) == 0) ? MONTH_DEC : MONTH_W'($urandom_range(1, 12));
            send_date(DAY_W'(days_in_month(int'(m), int'(y))), m, y);
        end
        wait_drained();
    endtask

    // short bursts; the sender holds off until all results are back
    task automatic test_pause_until_drained();
        gaps_on = 1'b0;
        repeat (5) begin
            repeat (20) begin
                if ($urandom_range(0, 3) == 0)
                    send_random_raw();
                else
                    send_random_valid();
            end
            wait_drained();
        end
    endtask

    // real dates mixed with unconstrained fields back to back, then raw with gaps
    task automatic test_raw_fields();
        gaps_on = 1'b0;
        repeat (200) begin
            if ($urandom_range(0, 9) < 7)
                send_random_valid();
            else
                send_random_raw();
        end
        gaps_on = 1'b1;
        repeat (250) send_random_raw();
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_valid_dates();
        test_month_and_year_ends();
        test_pause_until_drained();
        test_raw_fields();

        // pipeline is three stages deep; keep the clock running for stray items
        repeat (10) @(posedge aclk);

        $display("Sent %0d dates (%0d real, %0d invalid), checked %0d results.",
                 n_dates, n_valid, n_invalid, n_results);
        $display("Rollovers seen: %0d month ends, %0d year ends.",
                 n_month_roll, n_year_roll);
        if (n_errors == 0 && date_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Timed out with %0d results outstanding.", date_answers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
